FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, always on
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/bnf_pkg.sv
package bnf_pkg;

    localparam int CoordW       = 16;
    localparam int NormW        = 16;
    localparam int SumW         = 40;
    localparam int MaxNeighbors = 64;
    localparam int CntW         = $clog2(MaxNeighbors + 1);
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 16;

    localparam logic [CfgIdxW-1:0] CfgInvF = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgInvG = 2'd1;

    localparam logic [16:0] ExpLimit = 17'd3072;

    typedef enum logic {
        CMD_CENTER   = 1'b0,
        CMD_NEIGHBOR = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                        load;
        logic                        add;
        logic                        emit;
        logic [2:0][CoordW-1:0]      pos;
        logic [2:0][NormW-1:0]       norm;
    } t_op;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_TF,
        S_TG,
        S_EA,
        S_EB,
        S_W,
        S_ACC,
        S_MAG,
        S_NORM,
        S_N2,
        S_SQRT,
        S_DSET,
        S_DIV,
        S_OUT
    } t_bstate;

    function automatic logic [16:0] exp_whole(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_sixteenth(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_fine(input logic [3:0] l);
        logic [16:0] v;
        case (l)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

FILE: src/bnf_if.sv
interface bnf_item_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [bnf_pkg::CoordW-1:0]  pos_x;
    logic signed [bnf_pkg::CoordW-1:0]  pos_y;
    logic signed [bnf_pkg::CoordW-1:0]  pos_z;
    logic signed [bnf_pkg::NormW-1:0]   norm_x;
    logic signed [bnf_pkg::NormW-1:0]   norm_y;
    logic signed [bnf_pkg::NormW-1:0]   norm_z;
    logic                               neighbor_is_center;
    logic                               last_neighbor;

    modport source (output valid, command, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    neighbor_is_center, last_neighbor, input ready);
    modport sink (input valid, command, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  neighbor_is_center, last_neighbor, output ready);
endinterface

interface bnf_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [bnf_pkg::NormW-1:0]  filtered_x;
    logic signed [bnf_pkg::NormW-1:0]  filtered_y;
    logic signed [bnf_pkg::NormW-1:0]  filtered_z;
    logic                              sum_was_zero;

    modport source (output valid, filtered_x, filtered_y, filtered_z, sum_was_zero,
                    input ready);
    modport sink (input valid, filtered_x, filtered_y, filtered_z, sum_was_zero,
                  output ready);
endinterface

interface bnf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bnf_pkg::CfgIdxW-1:0]      index;
    logic [bnf_pkg::CfgDataW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/bilateral_normal_filter_top.sv
// center item: taken from the 2-entry queue by the idle back end and held as the centre
// neighbor item: dispatch, 6 squares, 2 scale, 4 exp, weight, 3 accumulate steps
// emit: a zero sum goes straight to output; else the sums pass the 1 to 30 step
// normalise shift, the 31-step square root and three divisions, one per axis
// result sits in an output register; meanwhile the queue keeps accepting until full
// synchronous active-low reset empties queue, clears centre, sums, count, output valid
module bilateral_normal_filter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bnf_item_if.sink  i_item,
    bnf_cfg_if.sink   i_cfg,
    bnf_result_if.source o_result
);
    import bnf_pkg::*;

    logic [CfgDataW-1:0] r_inv_f;
    logic [CfgDataW-1:0] r_inv_g;
    t_op                 op;
    t_qctl               qctl;
    logic                pop;
    logic                op_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_f <= CfgDataW'(256);
            r_inv_g <= CfgDataW'(256);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CfgInvF: r_inv_f <= i_cfg.data;
                CfgInvG: r_inv_g <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign qctl.valid = op_valid;
    assign qctl.pop   = pop;

    bnf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_pop      (qctl.pop),
        .o_op_valid (op_valid),
        .o_op       (op)
    );

    bnf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_qctl_in (qctl),
        .o_pop     (pop),
        .i_inv_f   (r_inv_f),
        .i_inv_g   (r_inv_g),
        .o_result  (o_result)
    );

endmodule

FILE: src/bnf_front.sv
module bnf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bnf_item_if.sink      i_item,
    input  logic          i_pop,
    output logic          o_op_valid,
    output bnf_pkg::t_op  o_op
);
    import bnf_pkg::*;

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_op        cls;

    // classify the incoming item
    always_comb begin
        cls.load = (t_cmd'(i_item.command) == CMD_CENTER);
        cls.add  = (t_cmd'(i_item.command) == CMD_NEIGHBOR) && !i_item.neighbor_is_center;
        cls.emit = (t_cmd'(i_item.command) == CMD_NEIGHBOR) && i_item.last_neighbor;
        cls.pos  = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
        cls.norm = {i_item.norm_z, i_item.norm_y, i_item.norm_x};
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_op_valid   = (r_cnt != 2'd0);
    assign o_op         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: src/bnf_back.sv
module bnf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bnf_pkg::t_op                  i_op,
    input  bnf_pkg::t_qctl                i_qctl_in,
    output logic                          o_pop,
    input  logic [bnf_pkg::CfgDataW-1:0]  i_inv_f,
    input  logic [bnf_pkg::CfgDataW-1:0]  i_inv_g,
    bnf_result_if.source                  o_result
);
    import bnf_pkg::*;

    t_bstate                   r_state;
    t_bstate                   n_state;
    t_op                       r_op;
    logic [2:0][CoordW-1:0]    r_cpos;
    logic [2:0][NormW-1:0]     r_cnorm;
    logic signed [SumW-1:0]    r_sum [3];
    logic [CntW-1:0]           r_cnt;
    logic [2:0]                r_i;
    logic [4:0]                r_k;
    logic [33:0]               r_accf;
    logic [33:0]               r_accg;
    logic [11:0]               r_tf;
    logic [11:0]               r_tg;
    logic                      r_tf_ovr;
    logic                      r_tg_ovr;
    logic                      r_eph;
    logic [16:0]               r_e;
    logic [16:0]               r_ef;
    logic [16:0]               r_eg;
    logic [16:0]               r_w;
    logic [SumW-1:0]           r_mag [3];
    logic                      r_zero;
    logic [61:0]               r_n2;
    logic [61:0]               r_rad;
    logic [33:0]               r_srem;
    logic [30:0]               r_root;
    logic [30:0]               r_drem;
    logic [15:0]               r_dnum;
    logic [15:0]               r_q;
    logic [2:0][NormW-1:0]     r_res;
    logic                      r_ovalid;
    logic [2:0][NormW-1:0]     r_ores;
    logic                      r_ozero;

    logic [1:0]                sel;
    logic signed [16:0]        dpos;
    logic signed [16:0]        dnrm;
    logic signed [16:0]        dsel;
    logic [16:0]               dmag;
    logic [33:0]               dsq;
    logic [49:0]               tprod;
    logic [23:0]               tf_full;
    logic [21:0]               tg_full;
    logic [11:0]               tcur;
    logic                      tovr;
    logic [33:0]               ea_prod;
    logic [33:0]               eb_prod;
    logic [33:0]               w_prod;
    logic [16:0]               ea;
    logic [16:0]               eb;
    logic signed [33:0]        term;
    logic signed [SumW:0]      s_wide;
    logic signed [SumW-1:0]    s_sat;
    logic                      hi30;
    logic                      hi29;
    logic                      all_zero;
    logic [59:0]               n2_term;
    logic [33:0]               rem2;
    logic [33:0]               trial;
    logic                      sq_ge;
    logic [31:0]               drem2;
    logic                      d_ge;
    logic [44:0]               dinit;
    logic [15:0]               qfin;
    logic                      out_free;
    logic                      under_cap;

    assign sel       = (r_i < 3'd3) ? r_i[1:0] : 2'(r_i - 3'd3);
    assign dpos      = $signed({r_op.pos[sel][CoordW-1], r_op.pos[sel]})
                     - $signed({r_cpos[sel][CoordW-1], r_cpos[sel]});
    assign dnrm      = $signed({r_op.norm[sel][NormW-1], r_op.norm[sel]})
                     - $signed({r_cnorm[sel][NormW-1], r_cnorm[sel]});
    assign dsel      = (r_i < 3'd3) ? dpos : dnrm;
    assign dmag      = dsel[16] ? 17'(-dsel) : 17'(dsel);
    assign dsq       = dmag * dmag;

    assign tprod     = (r_state == S_TF) ? (50'(r_accf) * 50'(i_inv_f))
                                         : (50'(r_accg) * 50'(i_inv_g));
    assign tf_full   = tprod[49:26];
    assign tg_full   = tprod[49:28];

    assign tcur      = r_eph ? r_tg : r_tf;
    assign tovr      = r_eph ? r_tg_ovr : r_tf_ovr;
    assign ea_prod   = exp_whole(tcur[11:8]) * exp_sixteenth(tcur[7:4]);
    assign ea        = 17'((ea_prod + 34'd32768) >> 16);
    assign eb_prod   = r_e * exp_fine(tcur[3:0]);
    assign eb        = tovr ? 17'd0 : 17'((eb_prod + 34'd32768) >> 16);
    assign w_prod    = r_ef * r_eg;

    assign term      = $signed({1'b0, r_w}) * $signed(r_op.norm[r_i[1:0]]);
    assign s_wide    = (SumW+1)'(r_sum[r_i[1:0]]) + (SumW+1)'(term);
    always_comb begin
        if (s_wide[SumW] != s_wide[SumW-1]) begin
            s_sat = s_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            s_sat = s_wide[SumW-1:0];
        end
    end

    assign hi30      = (|r_mag[0][SumW-1:30]) || (|r_mag[1][SumW-1:30])
                    || (|r_mag[2][SumW-1:30]);
    assign hi29      = (|r_mag[0][SumW-1:29]) || (|r_mag[1][SumW-1:29])
                    || (|r_mag[2][SumW-1:29]);
    assign all_zero  = (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0);
    assign n2_term   = r_mag[r_i[1:0]][29:0] * r_mag[r_i[1:0]][29:0];

    assign rem2      = {r_srem[31:0], r_rad[61:60]};
    assign trial     = {1'b0, r_root, 2'b01};
    assign sq_ge     = (rem2 >= trial);

    assign drem2     = {r_drem, r_dnum[15]};
    assign d_ge      = (drem2 >= {1'b0, r_root});
    assign dinit     = (45'(r_mag[r_i[1:0]][29:0]) << 14) + 45'(r_root >> 1);
    assign qfin      = {r_q[14:0], d_ge};

    assign out_free  = !r_ovalid || o_result.ready;
    assign under_cap = (r_cnt < CntW'(MaxNeighbors));
    assign o_pop     = (r_state == S_IDLE) && i_qctl_in.valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_qctl_in.valid && !i_op.load) begin
                    if (i_op.add && under_cap) begin
                        n_state = S_SQ;
                    end else if (i_op.emit) begin
                        n_state = S_MAG;
                    end
                end
            end
            S_SQ:   n_state = (r_i == 3'd5) ? S_TF : S_SQ;
            S_TF:   n_state = S_TG;
            S_TG:   n_state = S_EA;
            S_EA:   n_state = S_EB;
            S_EB:   n_state = r_eph ? S_W : S_EA;
            S_W:    n_state = S_ACC;
            S_ACC: begin
                if (r_i == 3'd2) begin
                    n_state = r_op.emit ? S_MAG : S_IDLE;
                end
            end
            S_MAG:  n_state = all_zero ? S_OUT : S_NORM;
            S_NORM: n_state = (!hi30 && hi29) ? S_N2 : S_NORM;
            S_N2:   n_state = (r_i == 3'd2) ? S_SQRT : S_N2;
            S_SQRT: n_state = (r_k == 5'd30) ? S_DSET : S_SQRT;
            S_DSET: n_state = S_DIV;
            S_DIV: begin
                if (r_k == 5'd15) begin
                    n_state = (r_i == 3'd2) ? S_OUT : S_DSET;
                end
            end
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_cpos   <= '0;
            r_cnorm  <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_IDLE && i_qctl_in.valid && i_op.load) begin
                r_cpos   <= i_op.pos;
                r_cnorm  <= i_op.norm;
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_cnt    <= '0;
            end
            if (r_state == S_ACC) begin
                r_sum[r_i[1:0]] <= s_sat;
                if (r_i == 3'd2) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op   <= i_op;
                r_i    <= '0;
                r_accf <= '0;
                r_accg <= '0;
                r_eph  <= 1'b0;
            end
            S_SQ: begin
                if (r_i < 3'd3) begin
                    r_accf <= r_accf + dsq;
                end else begin
                    r_accg <= r_accg + dsq;
                end
                r_i <= (r_i == 3'd5) ? 3'd0 : r_i + 3'd1;
            end
            S_TF: begin
                r_tf     <= tf_full[11:0];
                r_tf_ovr <= (tf_full >= 24'(ExpLimit));
            end
            S_TG: begin
                r_tg     <= tg_full[11:0];
                r_tg_ovr <= (tg_full >= 22'(ExpLimit));
            end
            S_EA: r_e <= ea;
            S_EB: begin
                if (r_eph) begin
                    r_eg <= eb;
                end else begin
                    r_ef <= eb;
                end
                r_eph <= 1'b1;
            end
            S_W: begin
                r_w <= 17'((w_prod + 34'd32768) >> 16);
                r_i <= '0;
            end
            S_ACC: r_i <= (r_i == 3'd2) ? 3'd0 : r_i + 3'd1;
            S_MAG: begin
                for (int c = 0; c < 3; c++) begin
                    r_mag[c] <= r_sum[c][SumW-1] ? SumW'(-r_sum[c]) : SumW'(r_sum[c]);
                end
                r_zero <= all_zero;
                r_res  <= '0;
                r_i    <= '0;
                r_n2   <= '0;
            end
            S_NORM: begin
                for (int c = 0; c < 3; c++) begin
                    if (hi30) begin
                        r_mag[c] <= r_mag[c] >> 1;
                    end else if (!hi29) begin
                        r_mag[c] <= r_mag[c] << 1;
                    end
                end
            end
            S_N2: begin
                r_n2 <= r_n2 + 62'(n2_term);
                r_i  <= (r_i == 3'd2) ? 3'd0 : r_i + 3'd1;
                r_k  <= '0;
                r_srem <= '0;
                r_root <= '0;
                r_rad  <= r_n2 + 62'(n2_term);
            end
            S_SQRT: begin
                r_srem <= sq_ge ? (rem2 - trial) : rem2;
                r_root <= {r_root[29:0], sq_ge};
                r_rad  <= r_rad << 2;
                r_k    <= (r_k == 5'd30) ? 5'd0 : r_k + 5'd1;
            end
            S_DSET: begin
                r_drem <= 31'(dinit[44:16]);
                r_dnum <= dinit[15:0];
                r_q    <= '0;
                r_k    <= '0;
            end
            S_DIV: begin
                r_drem <= d_ge ? 31'(drem2 - {1'b0, r_root}) : drem2[30:0];
                r_dnum <= r_dnum << 1;
                r_q    <= qfin;
                r_k    <= r_k + 5'd1;
                if (r_k == 5'd15) begin
                    r_res[r_i[1:0]] <= r_sum[r_i[1:0]][SumW-1] ? 16'(-qfin) : qfin;
                    r_i <= r_i + 3'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_ores  <= r_res;
                    r_ozero <= r_zero;
                end
            end
            default: r_i <= '0;
        endcase
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.filtered_x   = r_ores[0];
    assign o_result.filtered_y   = r_ores[1];
    assign o_result.filtered_z   = r_ores[2];
    assign o_result.sum_was_zero = r_ozero;

endmodule

FILE: src/bnf_checker.sv
`include "assert_macros.svh"

module bnf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [bnf_pkg::NormW-1:0]   i_fx,
    input logic [bnf_pkg::NormW-1:0]   i_fy,
    input logic [bnf_pkg::NormW-1:0]   i_fz,
    input logic                        i_zero
);
    import bnf_pkg::*;

    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `ASSERT_NEXT(a_item_stable, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_fx) && $stable(i_fy) && $stable(i_fz) && $stable(i_zero))
    `ASSERT_IMPLY(a_zero_result, i_clk, i_rst_n, i_valid && i_zero, i_fx == '0 && i_fy == '0 && i_fz == '0)
    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_valid)

endmodule

bind bilateral_normal_filter_top bnf_checker u_bnf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_fx    (o_result.filtered_x),
    .i_fy    (o_result.filtered_y),
    .i_fz    (o_result.filtered_z),
    .i_zero  (o_result.sum_was_zero)
);
